[hw/rtl/occupancy_propagation_stencil_top_defines.svh]
// assertion macros for the occupancy propagation stencil
// used by the top level, which supplies clk_i and rst_ni
`ifndef OCCUPANCY_PROPAGATION_STENCIL_TOP_DEFINES_SVH
`define OCCUPANCY_PROPAGATION_STENCIL_TOP_DEFINES_SVH

// property must hold at every edge out of reset
`define OPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never hold
`define OPS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/ops_pkg.sv]
// shared types, constants and helpers for the occupancy propagation stencil
// no dependencies
package ops_pkg;

  localparam int unsigned MaxRows    = 64;
  localparam int unsigned MaxCols    = 64;
  localparam int unsigned ValueBits  = 16;
  localparam int unsigned RowBits    = 6;
  localparam int unsigned ColBits    = 6;
  localparam int unsigned SizeBits   = 7;
  localparam int unsigned FactBits   = 17;
  localparam int unsigned EntryBits  = ValueBits + 1;
  localparam int unsigned StoreDepth = 3 * MaxCols;
  localparam int unsigned AddrBits   = 8;
  localparam int unsigned PaddrBits  = 5;

  localparam logic [SizeBits-1:0] SizeLimit    = 7'd64;
  localparam logic [SizeBits-1:0] ResetRows    = 7'd40;
  localparam logic [SizeBits-1:0] ResetCols    = 7'd40;
  localparam logic [FactBits-1:0] ResetDecay   = 17'd65536;
  localparam logic [FactBits-1:0] ResetGrowth  = 17'd0;

  typedef enum logic [2:0] {
    RegNumRows   = 3'd0,
    RegNumCols   = 3'd1,
    RegDecayEdge = 3'd2,
    RegDecayDiag = 3'd3,
    RegGrowth    = 3'd4
  } ops_reg_e;

  typedef struct packed {
    logic signed [ValueBits-1:0] cell_value;
    logic                        cell_is_wall;
  } ops_in_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] prop_value;
    logic [RowBits-1:0]          out_row;
    logic [ColBits-1:0]          out_col;
    logic                        run_last;
    logic                        frame_last;
  } ops_out_t;

  // row modulo three, by reciprocal multiply, exact for six-bit rows
  function automatic logic [1:0] mod3(input logic [RowBits-1:0] r);
    logic [12:0]        p;
    logic [RowBits-1:0] q;
    logic [RowBits-1:0] m;
    p = 13'(r) * 13'd43;
    q = p[12:7];
    m = r - 6'(q * 6'd3);
    return m[1:0];
  endfunction

  // grid size in use: zero acts as one, large values clip
  function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] v);
    logic [SizeBits-1:0] s;
    if (v == '0) s = 7'd1;
    else if (v > SizeLimit) s = SizeLimit;
    else s = v;
    return s;
  endfunction

endpackage

[hw/rtl/occupancy_propagation_stencil_top.sv]
// occupancy propagation stencil: line store, neighbour scan and lerp
// depends on ops_pkg and occupancy_propagation_stencil_top_defines.svh
//
// usage
// cells enter on in_valid_i / in_stall_o in row-major order, one value and
// wall flag per item. each item causes zero to four result items on
// out_valid_o / out_stall_i, each a finished cell with its row and column.
// registers are to be set over the APB port only while the block is idle;
// the block itself does not enforce this. an item is taken while idle, then
// each result it causes goes through reads of the single-port line store
// (the cell itself, its edge and its diagonal neighbours), multiply and compare,
// the growth multiply and the final add and saturate. input is stalled
// while results are being worked out. results land in an output register,
// so a stalled receiver holds only the last result; the next result waits
// in the S_FIN state while that register is still full. reset clears the
// position counters and the registers to their defaults; the line store is
// not cleared.
`include "occupancy_propagation_stencil_top_defines.svh"

module occupancy_propagation_stencil_top import ops_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ops_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ops_out_t             out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_LERP  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SizeBits-1:0] num_rows_q, num_cols_q;
  logic [FactBits-1:0] dec_e_q, dec_d_q, grow_q;
  logic [RowBits-1:0]  in_row_q, in_row_d;
  logic [ColBits-1:0]  in_col_q, in_col_d;
  logic [RowBits-1:0]  r_q;
  logic [ColBits-1:0]  c_q;
  logic [SizeBits-1:0] rows_q, cols_q;
  logic [3:0]          pend_q, pend_d;
  logic [3:0]          stp_q, stp_d;
  logic                drn_q, drn_d;
  logic                t_vld_q, t_inb_q;
  logic [3:0]          t_stp_q;
  logic [EntryBits-1:0] rdata_q;
  logic signed [ValueBits-1:0] self_val_q, best_q, best_d;
  logic                self_wall_q;
  logic [3:0]          ew_q;
  logic signed [33:0]  p_q, p_d;
  logic                pv_q, pv_d;
  logic signed [35:0]  lp_q;
  ops_out_t            out_q;
  logic                out_valid_q;

  logic [EntryBits-1:0] mem_q [StoreDepth];

  // configuration port
  logic cfg_we;
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= ResetRows;
      num_cols_q <= ResetCols;
      dec_e_q    <= ResetDecay;
      dec_d_q    <= ResetDecay;
      grow_q     <= ResetGrowth;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        RegNumRows:   num_rows_q <= pwdata[SizeBits-1:0];
        RegNumCols:   num_cols_q <= pwdata[SizeBits-1:0];
        RegDecayEdge: dec_e_q    <= pwdata[FactBits-1:0];
        RegDecayDiag: dec_d_q    <= pwdata[FactBits-1:0];
        RegGrowth:    grow_q     <= pwdata[FactBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegNumRows:   prdata = 32'(num_rows_q);
      RegNumCols:   prdata = 32'(num_cols_q);
      RegDecayEdge: prdata = 32'(dec_e_q);
      RegDecayDiag: prdata = 32'(dec_d_q);
      RegGrowth:    prdata = 32'(grow_q);
      default:      prdata = '0;
    endcase
  end

  // input position and emission plan
  logic                in_acc;
  logic [SizeBits-1:0] rows_eff, cols_eff, r_tmp, r_nxt;
  logic                col_wrap;
  logic [RowBits-1:0]  acc_r;
  logic [ColBits-1:0]  acc_c;
  logic [3:0]          acc_mask;
  logic                acc_first, acc_lastc, acc_lastr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign rows_eff   = eff_size(num_rows_q);
  assign cols_eff   = eff_size(num_cols_q);

  always_comb begin
    col_wrap  = ({1'b0, in_col_q} >= cols_eff);
    r_tmp     = col_wrap ? ({1'b0, in_row_q} + 7'd1) : {1'b0, in_row_q};
    acc_r     = (r_tmp >= rows_eff) ? '0 : r_tmp[RowBits-1:0];
    acc_c     = col_wrap ? '0 : in_col_q;
    acc_lastc = ({1'b0, acc_c} == cols_eff - 7'd1);
    acc_lastr = ({1'b0, acc_r} == rows_eff - 7'd1);
    acc_first = (acc_r != '0);
    acc_mask  = {acc_lastr & acc_lastc, acc_lastr & (acc_c != '0),
                 acc_first & acc_lastc, acc_first & (acc_c != '0)};
    r_nxt     = {1'b0, acc_r} + 7'd1;
    if (acc_lastc) begin
      in_col_d = '0;
      in_row_d = (r_nxt >= rows_eff) ? '0 : r_nxt[RowBits-1:0];
    end else begin
      in_col_d = acc_c + 6'd1;
      in_row_d = acc_r;
    end
  end

  // current result: lowest pending emission
  logic [1:0]         sel;
  logic [3:0]         sel_oh;
  logic [RowBits-1:0] er;
  logic [ColBits-1:0] ec;
  logic               res_last, res_frame;

  always_comb begin
    priority if (pend_q[0]) sel = 2'd0;
    else if (pend_q[1]) sel = 2'd1;
    else if (pend_q[2]) sel = 2'd2;
    else sel = 2'd3;
    sel_oh    = 4'b0001 << sel;
    er        = sel[1] ? r_q : r_q - 6'd1;
    ec        = sel[0] ? c_q : c_q - 6'd1;
    res_last  = ((pend_q & ~sel_oh) == '0);
    res_frame = ({1'b0, er} == rows_q - 7'd1) && ({1'b0, ec} == cols_q - 7'd1);
  end

  // neighbour address for the current step
  logic [1:0]         dr, dc;
  logic [7:0]         nr, nc;
  logic               inb;
  logic [AddrBits-1:0] rd_addr;

  always_comb begin
    unique case (stp_q)
      4'd1:    begin dr = 2'b11; dc = 2'b00; end
      4'd2:    begin dr = 2'b01; dc = 2'b00; end
      4'd3:    begin dr = 2'b00; dc = 2'b11; end
      4'd4:    begin dr = 2'b00; dc = 2'b01; end
      4'd5:    begin dr = 2'b11; dc = 2'b11; end
      4'd6:    begin dr = 2'b11; dc = 2'b01; end
      4'd7:    begin dr = 2'b01; dc = 2'b11; end
      4'd8:    begin dr = 2'b01; dc = 2'b01; end
      default: begin dr = 2'b00; dc = 2'b00; end
    endcase
    nr      = {2'b00, er} + {{6{dr[1]}}, dr};
    nc      = {2'b00, ec} + {{6{dc[1]}}, dc};
    inb     = (nr < {1'b0, rows_q}) && (nc < {1'b0, cols_q});
    rd_addr = {mod3(nr[RowBits-1:0]), nc[ColBits-1:0]};
  end

  // line store
  logic                mem_re;
  logic [AddrBits-1:0] wr_addr;
  assign mem_re  = (state_q == S_RUN);
  assign wr_addr = {mod3(acc_r), acc_c};

  always_ff @(posedge clk_i) begin
    if (in_acc) mem_q[wr_addr] <= {in_data_i.cell_is_wall, in_data_i.cell_value};
    if (mem_re) rdata_q <= mem_q[rd_addr];
  end

  // neighbour scale and maximum
  logic signed [ValueBits-1:0] rv, s_sat;
  logic                        rw, diag, diag_cut, incl;
  logic [FactBits-1:0]         fac;
  logic signed [17:0]          s_sh;

  always_comb begin
    rv       = rdata_q[ValueBits-1:0];
    rw       = rdata_q[ValueBits];
    diag     = (t_stp_q >= 4'd5);
    diag_cut = ((t_stp_q == 4'd5 || t_stp_q == 4'd6) ? ew_q[0] : ew_q[1]) |
               ((t_stp_q == 4'd5 || t_stp_q == 4'd7) ? ew_q[2] : ew_q[3]);
    incl     = t_inb_q & ~rw & (t_stp_q != '0) & ~(diag & diag_cut);
    fac      = diag ? dec_d_q : dec_e_q;
    p_d      = 34'(rv) * $signed({1'b0, fac});
    pv_d     = t_vld_q & incl;
    s_sh     = p_q[33:16];
    if (s_sh > 18'sd32767) s_sat = 16'sh7fff;
    else if (s_sh < -18'sd32768) s_sat = -16'sh8000;
    else s_sat = s_sh[ValueBits-1:0];
  end

  // growth lerp and saturation
  logic signed [17:0] diff;
  logic signed [20:0] sum;
  logic signed [ValueBits-1:0] fin_val;
  logic               out_free;

  always_comb begin
    diff = 18'(best_q) - 18'(self_val_q);
    sum  = 21'(self_val_q) + 21'($signed(lp_q[35:16]));
    if (self_wall_q) fin_val = '0;
    else if (sum > 21'sd32767) fin_val = 16'sh7fff;
    else if (sum < -21'sd32768) fin_val = -16'sh8000;
    else fin_val = sum[ValueBits-1:0];
    out_free = ~out_valid_q | ~out_stall_i;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    stp_d   = stp_q;
    drn_d   = drn_q;
    best_d  = best_q;
    if (pv_q && s_sat > best_q) best_d = s_sat;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && acc_mask != '0) begin
          state_d = S_RUN;
          pend_d  = acc_mask;
          stp_d   = '0;
          best_d  = '0;
        end
      end
      S_RUN: begin
        stp_d = stp_q + 4'd1;
        if (stp_q == 4'd8) begin
          state_d = S_DRAIN;
          drn_d   = 1'b0;
        end
      end
      S_DRAIN: begin
        drn_d = 1'b1;
        if (drn_q) state_d = S_LERP;
      end
      S_LERP: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          pend_d = pend_q & ~sel_oh;
          stp_d  = '0;
          best_d = '0;
          state_d = res_last ? S_IDLE : S_RUN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_row_q    <= '0;
      in_col_q    <= '0;
      pend_q      <= '0;
      stp_q       <= '0;
      drn_q       <= 1'b0;
      t_vld_q     <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      stp_q   <= stp_d;
      drn_q   <= drn_d;
      t_vld_q <= mem_re;
      pv_q    <= pv_d;
      if (in_acc) begin
        in_row_q <= in_row_d;
        in_col_q <= in_col_d;
      end
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    t_stp_q <= stp_q;
    t_inb_q <= inb;
    p_q     <= p_d;
    if (in_acc) begin
      r_q    <= acc_r;
      c_q    <= acc_c;
      rows_q <= rows_eff;
      cols_q <= cols_eff;
    end
    if (t_vld_q && t_stp_q == '0) begin
      self_val_q  <= rv;
      self_wall_q <= rw;
    end
    if (t_vld_q && t_stp_q >= 4'd1 && t_stp_q <= 4'd4) ew_q[t_stp_q[1:0] - 2'd1] <= rw;
    if (state_q == S_LERP) lp_q <= 36'(diff) * $signed({1'b0, grow_q});
    if (state_q == S_FIN && out_free) begin
      out_q.prop_value <= fin_val;
      out_q.out_row    <= er;
      out_q.out_col    <= ec;
      out_q.run_last   <= res_last;
      out_q.frame_last <= res_frame;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `OPS_ASSERT(a_idle_no_pend, (state_q == S_IDLE) |-> (pend_q == '0), "idle with pending results")
  `OPS_ASSERT(a_frame_run, (out_valid_o && out_data_o.frame_last) |-> out_data_o.run_last, "frame end not last of run")
  `OPS_NEVER(a_step_range, (state_q == S_RUN) && (stp_q > 4'd8), "neighbour step out of range")

endmodule
